/* rtl/ear_pkg.sv */
// Shared constants, codes and types of the energy anchor refiner.
`default_nettype none

package ear_pkg;

    // store geometry
    localparam int MAX_SAMPLES = 4096;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;

    // port widths
    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 13;
    localparam int OUT_W     = 12;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int HW_W      = 10;
    localparam int CFG_IDX_W = 1;

    // internal position width: covers count, span fields and pos + stride
    localparam int IDX_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // energy arithmetic
    localparam int LEN_W  = HW_W + 1;
    localparam int SQ_W   = 2 * SAMPLE_W - 1;
    localparam int SUM_W  = SQ_W + LEN_W - 1;
    localparam int PROD_W = SUM_W + LEN_W;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_REFINED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_STRIDE = 1'd1;

    localparam logic [HW_W-1:0] HALF_WINDOW_RST = 10'd120;
    localparam logic [HW_W-1:0] SCAN_STRIDE_RST = 10'd48;

    // compare kinds
    localparam logic KIND_GREATER = 1'b0;
    localparam logic KIND_BELOW   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QCHK,
        S_PK_ISSUE,
        S_PK_WAIT,
        S_PK_END,
        S_BK_CHK,
        S_BK_WAIT,
        S_FW_INIT,
        S_FW_CHK,
        S_FW_WAIT,
        S_OUT
    } ear_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_RUN,
        U_DRAIN,
        U_MUL_A,
        U_MUL_B,
        U_CMP
    } ear_ustate_t;

    typedef struct packed {
        logic              start;
        logic              peak_clr;
        logic              kind;
        logic [ADDR_W-1:0] lo;
        logic [LEN_W-1:0]  len;
    } ear_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic peak_zero;
    } ear_stat_t;

endpackage

`default_nettype wire

/* rtl/energy_anchor_refiner.sv */
// Top level: configuration registers, sample store, energy unit and sequencer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  in       | in_valid / in_ready   | mode, sample_value, span_start, span_end
//  out      | out_valid / out_ready | status, nucleus_pos, attack_end_pos, coda_start_pos
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Appends keep flowing while a result waits.
//  A query reads the clipped window of each scanned position from the store, one sample per
//  cycle; an invalid span skips the scans.
//  Positions visited: the peak scan over the span, then the backward and forward scans.
//  rst_n clears the sample count and restores the configuration defaults; store stays unknown.
//  in_ready is low for the whole query; out_valid holds until out_ready.
`default_nettype none

module energy_anchor_refiner
    import ear_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [MODE_W-1:0]          mode,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    input  wire logic [POS_W-1:0]           span_start,
    input  wire logic [POS_W-1:0]           span_end,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [STATUS_W-1:0]             status,
    output logic [OUT_W-1:0]                nucleus_pos,
    output logic [OUT_W-1:0]                attack_end_pos,
    output logic [OUT_W-1:0]                coda_start_pos,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [HW_W-1:0]            cfg_data
);

    logic [HW_W-1:0] half_window_reg;
    logic [HW_W-1:0] scan_stride_reg;

    logic                       store_we;
    logic [ADDR_W-1:0]          store_waddr;
    logic [ADDR_W-1:0]          store_raddr;
    logic signed [SAMPLE_W-1:0] store_rdata;
    ear_cmd_t                   cmd;
    ear_stat_t                  stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg <= HALF_WINDOW_RST;
            scan_stride_reg <= SCAN_STRIDE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HALF_WINDOW: half_window_reg <= cfg_data;
                REG_SCAN_STRIDE: scan_stride_reg <= cfg_data;
                default:         half_window_reg <= half_window_reg;
            endcase
        end
    end

    ear_store u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (sample_value),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    ear_energy u_energy (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (store_raddr),
        .rd_data (store_rdata),
        .stat    (stat)
    );

    ear_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .span_start     (span_start),
        .span_end       (span_end),
        .half_window    (half_window_reg),
        .scan_stride    (scan_stride_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .nucleus_pos    (nucleus_pos),
        .attack_end_pos (attack_end_pos),
        .coda_start_pos (coda_start_pos),
        .store_we       (store_we),
        .store_waddr    (store_waddr),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

`default_nettype wire

/* rtl/ear_store.sv */
// Sample store: one write port, one registered read port.
`default_nettype none

module ear_store
    import ear_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [ADDR_W-1:0]          waddr,
    input  wire logic signed [SAMPLE_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]          raddr,
    output logic signed [SAMPLE_W-1:0]      rdata
);

    logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/ear_energy.sv */
// Shared energy unit: window sum of squares, then cross-multiplied compare against the peak.
`default_nettype none

module ear_energy
    import ear_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ear_cmd_t                   cmd,
    output logic [ADDR_W-1:0]               rd_addr,
    input  wire logic signed [SAMPLE_W-1:0] rd_data,
    output ear_stat_t                       stat
);

    ear_ustate_t ustate_reg, ustate_next;

    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  left_reg;
    logic              rv_reg;
    logic              sqv_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              kind_reg;
    logic [SUM_W-1:0]  peak_sum_reg;
    logic [LEN_W-1:0]  peak_len_reg;
    logic [PROD_W-1:0] p1_reg;
    logic [PROD_W-1:0] p2_reg;
    logic              done_reg;
    logic              hit_reg;

    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [SUM_W-1:0]             mul_a;
    logic [LEN_W-1:0]             mul_b;
    logic [PROD_W-1:0]            prod;
    logic                         gt;
    logic                         below;
    logic                         cmp_hit;

    assign sq_full = rd_data * rd_data;

    // one multiplier: cur_sum * peak_len, then peak_sum * cur_len
    assign mul_a = (ustate_reg == U_MUL_A) ? sum_reg : peak_sum_reg;
    assign mul_b = (ustate_reg == U_MUL_A) ? peak_len_reg : len_reg;
    assign prod  = {{LEN_W{1'b0}}, mul_a} * {{SUM_W{1'b0}}, mul_b};

    assign gt      = p1_reg > p2_reg;
    assign below   = {p1_reg, 2'b00} < {2'b00, p2_reg};
    assign cmp_hit = (kind_reg == KIND_GREATER) ? gt : below;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustate_reg <= U_IDLE;
            rv_reg     <= 1'b0;
            sqv_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ustate_reg <= ustate_next;
            rv_reg     <= (ustate_reg == U_RUN);
            sqv_reg    <= rv_reg;
            done_reg   <= (ustate_reg == U_CMP);
        end
    end

    always_comb
    begin
        ustate_next = ustate_reg;
        unique case (ustate_reg)
            U_IDLE:
            begin
                if (cmd.start)
                begin
                    ustate_next = (cmd.len == '0) ? U_MUL_A : U_RUN;
                end
            end
            U_RUN:
            begin
                if (left_reg == LEN_W'(1))
                begin
                    ustate_next = U_DRAIN;
                end
            end
            U_DRAIN:
            begin
                if (!rv_reg && !sqv_reg)
                begin
                    ustate_next = U_MUL_A;
                end
            end
            U_MUL_A: ustate_next = U_MUL_B;
            U_MUL_B: ustate_next = U_CMP;
            U_CMP:   ustate_next = U_IDLE;
            default: ustate_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_full[SQ_W-1:0];

        if (ustate_reg == U_IDLE && cmd.start)
        begin
            addr_reg <= cmd.lo;
            left_reg <= cmd.len;
            kind_reg <= cmd.kind;
            sum_reg  <= '0;
            len_reg  <= (cmd.len == '0) ? LEN_W'(1) : cmd.len;
        end
        else
        begin
            if (ustate_reg == U_RUN)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
                left_reg <= left_reg - LEN_W'(1);
            end
            if (sqv_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
            end
        end

        if (ustate_reg == U_MUL_A)
        begin
            p1_reg <= prod;
        end
        if (ustate_reg == U_MUL_B)
        begin
            p2_reg <= prod;
        end
        if (ustate_reg == U_CMP)
        begin
            hit_reg <= cmp_hit;
        end

        if (cmd.peak_clr)
        begin
            peak_sum_reg <= '0;
            peak_len_reg <= LEN_W'(1);
        end
        else if (ustate_reg == U_CMP && kind_reg == KIND_GREATER && gt)
        begin
            peak_sum_reg <= sum_reg;
            peak_len_reg <= len_reg;
        end
    end

    assign rd_addr        = addr_reg;
    assign stat.done      = done_reg;
    assign stat.hit       = hit_reg;
    assign stat.peak_zero = (peak_sum_reg == '0);

endmodule

`default_nettype wire

/* rtl/ear_seq.sv */
// Sequencer: store fill, span scans for peak and half-level crossings, result register.
`default_nettype none

module ear_seq
    import ear_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [MODE_W-1:0]          mode,
    input  wire logic [POS_W-1:0]           span_start,
    input  wire logic [POS_W-1:0]           span_end,
    input  wire logic [HW_W-1:0]            half_window,
    input  wire logic [HW_W-1:0]            scan_stride,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [STATUS_W-1:0]             status,
    output logic [OUT_W-1:0]                nucleus_pos,
    output logic [OUT_W-1:0]                attack_end_pos,
    output logic [OUT_W-1:0]                coda_start_pos,
    output logic                            store_we,
    output logic [ADDR_W-1:0]               store_waddr,
    output ear_cmd_t                        cmd,
    input  wire ear_stat_t                  stat
);

    ear_state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg,      count_next;
    logic                out_valid_reg,  out_valid_next;
    logic [IDX_W-1:0]    start_reg,      start_next;
    logic [IDX_W-1:0]    end_reg,        end_next;
    logic [IDX_W-1:0]    stride_reg,     stride_next;
    logic [IDX_W-1:0]    pos_reg,        pos_next;
    logic [IDX_W-1:0]    peak_pos_reg,   peak_pos_next;
    logic [IDX_W-1:0]    attack_reg,     attack_next;
    logic [IDX_W-1:0]    coda_reg,       coda_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [OUT_W-1:0]    out_nuc_reg,    out_nuc_next;
    logic [OUT_W-1:0]    out_att_reg,    out_att_next;
    logic [OUT_W-1:0]    out_coda_reg,   out_coda_next;

    logic             accept;
    logic             out_free;
    logic [IDX_W-1:0] hw_x;
    logic [IDX_W-1:0] cnt_x;
    logic [IDX_W-1:0] lo_x;
    logic [IDX_W-1:0] hi_raw;
    logic [IDX_W-1:0] hi_x;
    logic [IDX_W-1:0] len_x;
    logic [IDX_W-1:0] pos_fwd;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // window of the current position, clipped to the filled part of the store
    assign hw_x    = IDX_W'(half_window);
    assign cnt_x   = IDX_W'(count_reg);
    assign lo_x    = (pos_reg > hw_x) ? pos_reg - hw_x : '0;
    assign hi_raw  = pos_reg + hw_x;
    assign hi_x    = (hi_raw > cnt_x) ? cnt_x : hi_raw;
    assign len_x   = (hi_x > lo_x) ? hi_x - lo_x : '0;
    assign pos_fwd = pos_reg + stride_reg;

    assign store_we    = accept && (mode == MODE_APPEND) && (count_reg < CNT_W'(MAX_SAMPLES));
    assign store_waddr = count_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        stride_reg     <= stride_next;
        pos_reg        <= pos_next;
        peak_pos_reg   <= peak_pos_next;
        attack_reg     <= attack_next;
        coda_reg       <= coda_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_nuc_reg    <= out_nuc_next;
        out_att_reg    <= out_att_next;
        out_coda_reg   <= out_coda_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        start_next      = start_reg;
        end_next        = end_reg;
        stride_next     = stride_reg;
        pos_next        = pos_reg;
        peak_pos_next   = peak_pos_reg;
        attack_next     = attack_reg;
        coda_next       = coda_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_nuc_next    = out_nuc_reg;
        out_att_next    = out_att_reg;
        out_coda_next   = out_coda_reg;

        cmd.start    = 1'b0;
        cmd.peak_clr = 1'b0;
        cmd.kind     = KIND_GREATER;
        cmd.lo       = lo_x[ADDR_W-1:0];
        cmd.len      = len_x[LEN_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (mode == MODE_CLEAR)
                    begin
                        count_next = '0;
                    end
                    if (mode == MODE_QUERY)
                    begin
                        start_next  = IDX_W'(span_start);
                        end_next    = IDX_W'(span_end);
                        stride_next = (scan_stride == '0) ? IDX_W'(1) : IDX_W'(scan_stride);
                        state_next  = S_QCHK;
                    end
                end
            end
            S_QCHK:
            begin
                if (end_reg <= start_reg || end_reg > cnt_x)
                begin
                    res_status_next = ST_INVALID;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.peak_clr  = 1'b1;
                    pos_next      = start_reg;
                    peak_pos_next = start_reg;
                    state_next    = S_PK_ISSUE;
                end
            end
            S_PK_ISSUE:
            begin
                cmd.start  = 1'b1;
                cmd.kind   = KIND_GREATER;
                state_next = S_PK_WAIT;
            end
            S_PK_WAIT:
            begin
                if (stat.done)
                begin
                    if (stat.hit)
                    begin
                        peak_pos_next = pos_reg;
                    end
                    if (pos_fwd < end_reg)
                    begin
                        pos_next   = pos_fwd;
                        state_next = S_PK_ISSUE;
                    end
                    else
                    begin
                        state_next = S_PK_END;
                    end
                end
            end
            S_PK_END:
            begin
                if (stat.peak_zero)
                begin
                    res_status_next = ST_ZERO;
                    state_next      = S_OUT;
                end
                else
                begin
                    res_status_next = ST_REFINED;
                    pos_next        = peak_pos_reg;
                    attack_next     = peak_pos_reg;
                    coda_next       = peak_pos_reg;
                    state_next      = S_BK_CHK;
                end
            end
            S_BK_CHK:
            begin
                if (pos_reg > start_reg)
                begin
                    cmd.start  = 1'b1;
                    cmd.kind   = KIND_BELOW;
                    state_next = S_BK_WAIT;
                end
                else
                begin
                    state_next = S_FW_INIT;
                end
            end
            S_BK_WAIT:
            begin
                if (stat.done)
                begin
                    if (stat.hit)
                    begin
                        attack_next = pos_reg;
                        state_next  = S_FW_INIT;
                    end
                    else if (pos_reg < stride_reg)
                    begin
                        state_next = S_FW_INIT;
                    end
                    else
                    begin
                        pos_next   = pos_reg - stride_reg;
                        state_next = S_BK_CHK;
                    end
                end
            end
            S_FW_INIT:
            begin
                pos_next   = peak_pos_reg;
                state_next = S_FW_CHK;
            end
            S_FW_CHK:
            begin
                if (pos_reg < end_reg)
                begin
                    cmd.start  = 1'b1;
                    cmd.kind   = KIND_BELOW;
                    state_next = S_FW_WAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_FW_WAIT:
            begin
                if (stat.done)
                begin
                    if (stat.hit)
                    begin
                        coda_next  = pos_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pos_next   = pos_fwd;
                        state_next = S_FW_CHK;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    if (res_status_reg == ST_REFINED)
                    begin
                        out_nuc_next  = peak_pos_reg[OUT_W-1:0];
                        out_att_next  = attack_reg[OUT_W-1:0];
                        out_coda_next = coda_reg[OUT_W-1:0];
                    end
                    else
                    begin
                        out_nuc_next  = '0;
                        out_att_next  = '0;
                        out_coda_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign nucleus_pos    = out_nuc_reg;
    assign attack_end_pos = out_att_reg;
    assign coda_start_pos = out_coda_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == S_PK_WAIT || state_reg == S_BK_WAIT
                       || state_reg == S_FW_WAIT))
        else $error("energy unit finished outside a wait state");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (state_reg == S_IDLE && count_reg < CNT_W'(MAX_SAMPLES)))
        else $error("store written while busy or full");
`endif

endmodule

`default_nettype wire

/* sim/energy_anchor_refiner_checker.sv */
// Checker for the energy anchor refiner: mirrors store and registers, predicts and compares results.
`timescale 1ns / 100ps

module energy_anchor_refiner_checker
    import ear_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [POS_W-1:0]           span_start,
    input  logic [POS_W-1:0]           span_end,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [STATUS_W-1:0]        status,
    input  logic [OUT_W-1:0]           nucleus_pos,
    input  logic [OUT_W-1:0]           attack_end_pos,
    input  logic [OUT_W-1:0]           coda_start_pos,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [HW_W-1:0]            cfg_data,
    output int                         mismatches,
    output int                         pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    nucleus;
        logic [OUT_W-1:0]    attack;
        logic [OUT_W-1:0]    coda;
    } anchor_t;

    // sum of squares over a window and the window length
    typedef struct packed {
        logic [63:0] sum;
        logic [63:0] len;
    } energy_t;

    logic signed [SAMPLE_W-1:0] store_copy [MAX_SAMPLES];
    int unsigned                fill;
    logic [HW_W-1:0]            half_win;
    logic [HW_W-1:0]            stride_cfg;
    anchor_t                    anchors_due [$];
    int unsigned                results_seen;

    function automatic energy_t frame_energy(input int unsigned center);
        energy_t     e;
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        longint      v;
        e.sum = 64'd0;
        e.len = 64'd1;
        lo = (center > half_win) ? center - half_win : 0;
        hi = center + half_win;
        if (hi > fill)
            hi = fill;
        if (hi <= lo)
            return e;
        e.len = 64'(hi - lo);
        for (i = lo; i < hi; i++)
        begin
            v = store_copy[i];
            e.sum += 64'(v * v);
        end
        return e;
    endfunction

    function automatic logic louder(input energy_t a, input energy_t b);
        return a.sum * b.len > b.sum * a.len;
    endfunction

    // mean square of a under a quarter of the peak mean square
    function automatic logic under_half_rms(input energy_t a, input energy_t pk);
        return 64'd4 * a.sum * pk.len < pk.sum * a.len;
    endfunction

    function automatic anchor_t refine_span(input int unsigned first, input int unsigned stop);
        anchor_t     r;
        energy_t     peak;
        energy_t     e;
        int unsigned hop;
        int unsigned pos;
        int unsigned peak_at;
        int unsigned attack;
        int unsigned coda;
        r = '0;
        if (stop <= first || stop > fill)
        begin
            r.status = ST_INVALID;
            return r;
        end
        hop = (stride_cfg == '0) ? 1 : stride_cfg;
        peak.sum = 64'd0;
        peak.len = 64'd1;
        peak_at = first;
        for (pos = first; pos < stop; pos += hop)
        begin
            e = frame_energy(pos);
            if (louder(e, peak))
            begin
                peak = e;
                peak_at = pos;
            end
        end
        if (peak.sum == 64'd0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        attack = peak_at;
        for (pos = peak_at; pos > first; pos -= hop)
        begin
            if (under_half_rms(frame_energy(pos), peak))
            begin
                attack = pos;
                break;
            end
            if (pos < hop)
                break;
        end
        coda = peak_at;
        for (pos = peak_at; pos < stop; pos += hop)
        begin
            if (under_half_rms(frame_energy(pos), peak))
            begin
                coda = pos;
                break;
            end
        end
        r.status  = ST_REFINED;
        r.nucleus = OUT_W'(peak_at);
        r.attack  = OUT_W'(attack);
        r.coda    = OUT_W'(coda);
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        anchor_t got;
        anchor_t want;
        if (!rst_n)
        begin
            fill = 0;
            half_win = HALF_WINDOW_RST;
            stride_cfg = SCAN_STRIDE_RST;
            anchors_due.delete();
            results_seen = 0;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {status, nucleus_pos, attack_end_pos, coda_start_pos};
                if (anchors_due.size() == 0)
                    note_mismatch($sformatf("unexpected result beat: status %0d nucleus %0d",
                                            got.status, got.nucleus));
                else
                begin
                    want = anchors_due.pop_front();
                    if (got.status !== want.status || got.nucleus !== want.nucleus ||
                        got.attack !== want.attack || got.coda !== want.coda)
                        note_mismatch($sformatf({"result %0d (expected/actual): status %0d/%0d ",
                                                 "nucleus %0d/%0d attack %0d/%0d coda %0d/%0d"},
                                                results_seen, want.status, got.status,
                                                want.nucleus, got.nucleus, want.attack,
                                                got.attack, want.coda, got.coda));
                end
                results_seen++;
            end
            if (in_valid && in_ready)
            begin
                case (mode)
                    MODE_APPEND:
                        if (fill < MAX_SAMPLES)
                        begin
                            store_copy[fill] = sample_value;
                            fill++;
                        end
                    MODE_CLEAR:
                        fill = 0;
                    MODE_QUERY:
                        anchors_due.insert(anchors_due.size(),
                                           refine_span(span_start, span_end));
                    default:
                        ;
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HALF_WINDOW)
                    half_win = cfg_data;
                else if (cfg_index == REG_SCAN_STRIDE)
                    stride_cfg = cfg_data;
            end
            pending <= anchors_due.size();
        end
    end

endmodule

/* sim/energy_anchor_refiner_tb.sv */
// Testbench top for the energy anchor refiner: sample, clear and query stimulus and the verdict.
`timescale 1ns / 100ps

module energy_anchor_refiner_tb;
    import ear_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 200000;
    localparam int QUERY_BUDGET = 800;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [POS_W-1:0]           span_start;
    logic [POS_W-1:0]           span_end;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic [OUT_W-1:0]           nucleus_pos;
    logic [OUT_W-1:0]           attack_end_pos;
    logic [OUT_W-1:0]           coda_start_pos;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [HW_W-1:0]            cfg_data;
    int                         mismatches;
    int                         pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned stored;
    int unsigned hw_now;
    int unsigned stride_now;
    int unsigned beats_sent;
    int          stall_cycles = 0;

    energy_anchor_refiner u_top (.*);

    energy_anchor_refiner_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // no beat on any channel for too long means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("energy_anchor_refiner test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [SAMPLE_W-1:0] s,
                             input int unsigned first, input int unsigned stop);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        sample_value <= s;
        span_start   <= POS_W'(first);
        span_end     <= POS_W'(stop);
        do @(posedge clk); while (!in_ready);
        if (m != MODE_UNUSED)
            beats_sent++;
        if (m == MODE_APPEND && stored < MAX_SAMPLES)
            stored++;
        else if (m == MODE_CLEAR)
            stored = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= HW_W'(val);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_HALF_WINDOW)
            hw_now = val;
        else
            stride_now = val;
    endtask

    // drop valid, wait for every outstanding result, then let trailing appends finish
    task automatic settle;
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned hw, input int unsigned stride);
        settle();
        write_reg(REG_HALF_WINDOW, hw);
        write_reg(REG_SCAN_STRIDE, stride);
    endtask

    function automatic int unsigned random_level();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 3;
            2: return 60;
            3: return 1000;
            4: return 12000;
            default: return 32767;
        endcase
    endfunction

    task automatic append_run(input int unsigned n, input int unsigned amp);
        int unsigned         k;
        logic [SAMPLE_W-1:0] s;
        for (k = 0; k < n; k++)
        begin
            if (amp >= 32767)
                s = SAMPLE_W'($urandom_range(0, 65535));
            else
                s = SAMPLE_W'($urandom_range(0, 2 * amp) - amp);
            send_beat(MODE_APPEND, s, $urandom_range(0, MAX_SAMPLES),
                      $urandom_range(0, MAX_SAMPLES));
        end
    endtask

    // valid span whose scanned positions are limited by QUERY_BUDGET and the window size
    task automatic query_valid;
        int unsigned hop;
        int unsigned reach;
        int unsigned len;
        int unsigned first;
        hop = (stride_now == 0) ? 1 : stride_now;
        reach = QUERY_BUDGET / (2 * hw_now + 10);
        if (reach == 0)
            reach = 1;
        reach = reach * hop;
        if (reach > stored)
            reach = stored;
        len = $urandom_range(1, reach);
        first = $urandom_range(0, stored - len);
        send_beat(MODE_QUERY, SAMPLE_W'($urandom), first, first + len);
    endtask

    task automatic query_broken;
        int unsigned first;
        int unsigned stop;
        if ($urandom_range(0, 1) == 0 || stored >= MAX_SAMPLES)
        begin
            first = $urandom_range(0, MAX_SAMPLES);
            stop = $urandom_range(0, first);
        end
        else
        begin
            stop = $urandom_range(stored + 1, MAX_SAMPLES);
            first = $urandom_range(0, stop - 1);
        end
        send_beat(MODE_QUERY, SAMPLE_W'($urandom), first, stop);
    endtask

    task automatic random_config;
        int unsigned hw;
        int unsigned stride;
        hw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 40);
        case ($urandom_range(0, 3))
            0, 1: stride = $urandom_range(1, 8);
            2: stride = $urandom_range(1, 1023);
            default: stride = $urandom_range(9, 100);
        endcase
        set_config(hw, stride);
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned goal;
        int unsigned pick;
        goal = beats_sent + quota;
        while (beats_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_beat(MODE_CLEAR, SAMPLE_W'($urandom), $urandom_range(0, MAX_SAMPLES),
                          $urandom_range(0, MAX_SAMPLES));
                append_run($urandom_range(1, 24), random_level());
            end
            else if (pick < 45 || stored == 0)
                append_run($urandom_range(1, 24), random_level());
            else if (pick < 85)
                query_valid();
            else if (pick < 96)
                query_broken();
            else
                send_beat(MODE_UNUSED, SAMPLE_W'($urandom), $urandom_range(0, MAX_SAMPLES),
                          $urandom_range(0, MAX_SAMPLES));
        end
    endtask

    task automatic fill_store;
        int unsigned n;
        set_config(1023, 1023);
        send_beat(MODE_CLEAR, '0, 0, 0);
        while (stored < MAX_SAMPLES)
        begin
            n = $urandom_range(16, 256);
            if (n > MAX_SAMPLES - stored)
                n = MAX_SAMPLES - stored;
            append_run(n, random_level());
        end
        // store is full: these beats are dropped
        append_run(4, 32767);
        send_beat(MODE_QUERY, '0, 0, MAX_SAMPLES);
        set_config(HALF_WINDOW_RST, SCAN_STRIDE_RST);
        send_beat(MODE_QUERY, '0, MAX_SAMPLES - 96, MAX_SAMPLES);
        send_beat(MODE_QUERY, '0, MAX_SAMPLES, MAX_SAMPLES);
        repeat (6) query_valid();
        repeat (3) query_broken();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_APPEND;
        sample_value = '0;
        span_start = '0;
        span_end = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_HALF_WINDOW;
        cfg_data = '0;
        send_idle_pct = 22;
        recv_idle_pct = 50;
        stored = 0;
        hw_now = HALF_WINDOW_RST;
        stride_now = SCAN_STRIDE_RST;
        beats_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, a short loud burst between silences
        send_beat(MODE_QUERY, '0, 0, 1);
        set_config(2, 0);
        repeat (3) send_beat(MODE_APPEND, 16'h0000, 0, 0);
        repeat (2)
        begin
            send_beat(MODE_APPEND, 16'h7FFF, 0, 0);
            send_beat(MODE_APPEND, 16'h8000, 0, 0);
        end
        repeat (3) send_beat(MODE_APPEND, 16'h0000, 0, 0);
        send_beat(MODE_QUERY, '0, 0, 10);
        send_beat(MODE_QUERY, '0, 0, 2);
        send_beat(MODE_QUERY, '0, 5, 5);
        send_beat(MODE_QUERY, '0, 7, 3);
        send_beat(MODE_QUERY, '0, 0, 11);
        send_beat(MODE_UNUSED, 16'hFFFF, 8191, 8191);
        set_config(0, 3);
        send_beat(MODE_QUERY, '0, 0, 10);
        set_config(1023, 1023);
        send_beat(MODE_QUERY, '0, 0, 10);
        send_beat(MODE_CLEAR, '0, 0, 0);
        send_beat(MODE_QUERY, '0, 0, 1);

        repeat (2)
        begin
            random_config();
            random_phase(333);
        end
        send_idle_pct = 50;
        recv_idle_pct = 22;
        repeat (2)
        begin
            random_config();
            random_phase(333);
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2)
        begin
            random_config();
            random_phase(333);
        end
        fill_store();

        settle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("energy_anchor_refiner test passed");
        else
            $display("energy_anchor_refiner test failed");
        $finish;
    end

endmodule
